// ===== rtl/core/ght_pkg.sv =====
package ght_pkg;

	localparam int SLOT_BITS  = 10;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int HANDLE_W   = 16;

	localparam logic [HANDLE_W-1:0] GEN_STEP    = 16'd1024;
	localparam logic [HANDLE_W-1:0] ROOT_HANDLE = 16'd0;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [SLOT_BITS:0]   cnt_t;
	// msb set: slot holds no entry
	typedef logic [SLOT_BITS:0]   pos_t;
	typedef logic [HANDLE_W-1:0]  handle_t;

	localparam pos_t POS_ABSENT = '1;

	localparam logic [2:0] FUNC_ADD    = 3'd0;
	localparam logic [2:0] FUNC_REMOVE = 3'd1;
	localparam logic [2:0] FUNC_QUERY  = 3'd2;
	localparam logic [2:0] FUNC_SET    = 3'd3;
	localparam logic [2:0] FUNC_GET    = 3'd4;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_FULL    = 2'd1;
	localparam logic [1:0] STS_UNKNOWN = 2'd2;

	localparam logic [1:0] RES_ZERO   = 2'd0;
	localparam logic [1:0] RES_TAG    = 2'd1;
	localparam logic [1:0] RES_PARENT = 2'd2;

	typedef struct packed {
		logic       clr;
		logic       cap;
		logic       rd_ph;
		logic       rd_pos;
		logic       pos_cap;
		logic       wr_add;
		logic       wr_rm1;
		logic       wr_rm2;
		logic       wr_par;
		logic       out_ld;
		logic       out_found;
		logic [1:0] out_status;
		logic [1:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [2:0] func;
		logic       full;
		logic       live_h;
		logic       live_ph;
		logic       ph_root;
	} sts_t;

endpackage

// ===== rtl/core/ght_ram.sv =====
module ght_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ght_ctrl.sv =====
module ght_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ght_pkg::sts_t sts,
	output ght_pkg::cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_ONE   = 2'd2;
	localparam logic [1:0] S_TWO   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_ONE;
				end
			end
			S_ONE: begin
				cmd.pos_cap = 1'b1;
				state_d     = S_IDLE;
				case (sts.func)
					ght_pkg::FUNC_ADD: begin
						cmd.out_ld = 1'b1;
						if (sts.full) begin
							cmd.out_status = ght_pkg::STS_FULL;
						end else begin
							cmd.wr_add    = 1'b1;
							cmd.out_found = 1'b1;
							cmd.res_sel   = ght_pkg::RES_TAG;
						end
					end
					ght_pkg::FUNC_REMOVE: begin
						if (sts.live_h) begin
							cmd.wr_rm1 = 1'b1;
							state_d    = S_TWO;
						end else begin
							cmd.out_ld     = 1'b1;
							cmd.out_status = ght_pkg::STS_UNKNOWN;
						end
					end
					ght_pkg::FUNC_QUERY: begin
						cmd.out_ld    = 1'b1;
						cmd.out_found = sts.live_h;
					end
					ght_pkg::FUNC_SET: begin
						if (sts.live_h) begin
							cmd.rd_ph = 1'b1;
							state_d   = S_TWO;
						end else begin
							cmd.out_ld     = 1'b1;
							cmd.out_status = ght_pkg::STS_UNKNOWN;
						end
					end
					ght_pkg::FUNC_GET: begin
						if (sts.live_h) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_TWO;
						end else begin
							cmd.out_ld     = 1'b1;
							cmd.out_status = ght_pkg::STS_UNKNOWN;
						end
					end
					default: begin
						cmd.out_ld = 1'b1;
					end
				endcase
			end
			S_TWO: begin
				state_d       = S_IDLE;
				cmd.out_ld    = 1'b1;
				cmd.out_found = 1'b1;
				case (sts.func)
					ght_pkg::FUNC_REMOVE: begin
						cmd.wr_rm2 = 1'b1;
					end
					ght_pkg::FUNC_SET: begin
						if (sts.ph_root || sts.live_ph) begin
							cmd.wr_par = 1'b1;
						end else begin
							cmd.out_status = ght_pkg::STS_UNKNOWN;
						end
					end
					ght_pkg::FUNC_GET: begin
						cmd.res_sel = ght_pkg::RES_PARENT;
					end
					default: begin
						cmd.out_found = 1'b0;
					end
				endcase
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/core/ght_datapath.sv =====
module ght_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ght_pkg::cmd_t           cmd,
	output ght_pkg::sts_t           sts,
	input  logic [2:0]              func,
	input  ght_pkg::handle_t        handle,
	input  ght_pkg::handle_t        parent_handle,
	output logic                    done,
	output ght_pkg::handle_t        result_handle,
	output logic                    found,
	output logic [1:0]              status
);

	localparam int SB  = ght_pkg::SLOT_BITS;
	localparam int PAD = ght_pkg::HANDLE_W - SB;

	logic [2:0]          func_q;
	ght_pkg::handle_t    handle_q;
	ght_pkg::handle_t    ph_q;
	ght_pkg::slot_t      pos_q;
	ght_pkg::slot_t      clr_q;
	ght_pkg::cnt_t       live_q;
	ght_pkg::slot_t      head_q;
	ght_pkg::slot_t      tail_q;
	ght_pkg::handle_t    res_q;
	logic                found_q;
	logic [1:0]          status_q;
	logic                done_q;

	ght_pkg::handle_t    tag_rd;
	ght_pkg::slot_t      link_rd;
	ght_pkg::pos_t       pos_rd;
	ght_pkg::handle_t    eh_rd;
	ght_pkg::handle_t    ep_rd;

	ght_pkg::slot_t      tag_addr;
	ght_pkg::slot_t      pos_addr;
	ght_pkg::slot_t      link_addr;
	ght_pkg::slot_t      ent_addr;
	ght_pkg::handle_t    tag_wd;
	ght_pkg::pos_t       pos_wd;
	ght_pkg::slot_t      link_wd;
	ght_pkg::handle_t    eh_wd;
	ght_pkg::handle_t    ep_wd;
	ght_pkg::handle_t    new_tag;
	ght_pkg::handle_t    clr_ext;
	ght_pkg::slot_t      live_lo;
	ght_pkg::slot_t      last;
	ght_pkg::slot_t      rd_slot;
	logic                slot_re;

	assign new_tag = tag_rd + ght_pkg::GEN_STEP;
	assign clr_ext = {{PAD{1'b0}}, clr_q};
	assign live_lo = live_q[SB-1:0];
	assign last    = live_lo - 1'b1;
	assign slot_re = cmd.cap | cmd.rd_ph;
	assign rd_slot = (func == ght_pkg::FUNC_ADD) ? head_q : handle[SB-1:0];

	always_comb begin
		if (cmd.clr) begin
			tag_addr = clr_q;
		end else if (cmd.cap) begin
			tag_addr = rd_slot;
		end else if (cmd.rd_ph) begin
			tag_addr = ph_q[SB-1:0];
		end else begin
			tag_addr = head_q;
		end
		tag_wd = cmd.clr ? clr_ext : new_tag;

		if (cmd.clr) begin
			pos_addr = clr_q;
		end else if (cmd.cap) begin
			pos_addr = rd_slot;
		end else if (cmd.rd_ph) begin
			pos_addr = ph_q[SB-1:0];
		end else if (cmd.wr_rm1) begin
			pos_addr = eh_rd[SB-1:0];
		end else if (cmd.wr_rm2) begin
			pos_addr = handle_q[SB-1:0];
		end else begin
			pos_addr = head_q;
		end
		if (cmd.clr || cmd.wr_rm2) begin
			pos_wd = ght_pkg::POS_ABSENT;
		end else if (cmd.wr_rm1) begin
			pos_wd = {1'b0, pos_rd[SB-1:0]};
		end else begin
			pos_wd = {1'b0, live_lo};
		end

		if (cmd.clr) begin
			link_addr = clr_q;
		end else if (cmd.wr_rm1) begin
			link_addr = tail_q;
		end else begin
			link_addr = head_q;
		end
		link_wd = cmd.clr ? clr_q + 1'b1 : handle_q[SB-1:0];

		if (cmd.clr) begin
			ent_addr = clr_q;
		end else if (cmd.wr_add) begin
			ent_addr = live_lo;
		end else if (cmd.wr_rm1 || cmd.rd_pos) begin
			ent_addr = pos_rd[SB-1:0];
		end else if (cmd.wr_par) begin
			ent_addr = pos_q;
		end else begin
			ent_addr = last;
		end
		if (cmd.clr) begin
			eh_wd = clr_ext;
		end else if (cmd.wr_rm1) begin
			eh_wd = eh_rd;
		end else begin
			eh_wd = new_tag;
		end
		if (cmd.wr_rm1) begin
			ep_wd = ep_rd;
		end else if (cmd.wr_par) begin
			ep_wd = ph_q;
		end else begin
			ep_wd = ght_pkg::ROOT_HANDLE;
		end
	end

	ght_ram #(.WIDTH(ght_pkg::HANDLE_W), .DEPTH(ght_pkg::SLOT_COUNT)) u_slot_tag (
		.clk   (clk),
		.we    (cmd.clr | cmd.wr_add),
		.re    (slot_re),
		.addr  (tag_addr),
		.wdata (tag_wd),
		.rdata (tag_rd)
	);

	ght_ram #(.WIDTH(SB + 1), .DEPTH(ght_pkg::SLOT_COUNT)) u_slot_pos (
		.clk   (clk),
		.we    (cmd.clr | cmd.wr_add | cmd.wr_rm1 | cmd.wr_rm2),
		.re    (slot_re),
		.addr  (pos_addr),
		.wdata (pos_wd),
		.rdata (pos_rd)
	);

	ght_ram #(.WIDTH(SB), .DEPTH(ght_pkg::SLOT_COUNT)) u_slot_link (
		.clk   (clk),
		.we    (cmd.clr | (cmd.wr_rm1 & ~sts.full)),
		.re    (cmd.cap),
		.addr  (link_addr),
		.wdata (link_wd),
		.rdata (link_rd)
	);

	ght_ram #(.WIDTH(ght_pkg::HANDLE_W), .DEPTH(ght_pkg::SLOT_COUNT)) u_entry_handle (
		.clk   (clk),
		.we    (cmd.clr | cmd.wr_add | cmd.wr_rm1),
		.re    (cmd.cap | cmd.rd_pos),
		.addr  (ent_addr),
		.wdata (eh_wd),
		.rdata (eh_rd)
	);

	ght_ram #(.WIDTH(ght_pkg::HANDLE_W), .DEPTH(ght_pkg::SLOT_COUNT)) u_entry_parent (
		.clk   (clk),
		.we    (cmd.clr | cmd.wr_add | cmd.wr_rm1 | cmd.wr_par),
		.re    (cmd.cap | cmd.rd_pos),
		.addr  (ent_addr),
		.wdata (ep_wd),
		.rdata (ep_rd)
	);

	assign sts.clr_last = &clr_q;
	assign sts.func     = func_q;
	assign sts.full     = live_q[SB];
	assign sts.live_h   = (tag_rd == handle_q) && !pos_rd[SB];
	assign sts.live_ph  = (tag_rd == ph_q) && !pos_rd[SB];
	assign sts.ph_root  = (ph_q == ght_pkg::ROOT_HANDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			live_q <= ght_pkg::cnt_t'(1);
			head_q <= ght_pkg::slot_t'(1);
			tail_q <= '1;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_ld;
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.wr_add) begin
				live_q <= live_q + 1'b1;
				head_q <= link_rd;
			end
			if (cmd.wr_rm1) begin
				live_q <= live_q - 1'b1;
				tail_q <= handle_q[SB-1:0];
				if (sts.full) begin
					head_q <= handle_q[SB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q   <= func;
			handle_q <= handle;
			ph_q     <= parent_handle;
		end
		if (cmd.pos_cap) begin
			pos_q <= pos_rd[SB-1:0];
		end
		if (cmd.out_ld) begin
			found_q  <= cmd.out_found;
			status_q <= cmd.out_status;
			case (cmd.res_sel)
				ght_pkg::RES_TAG:    res_q <= new_tag;
				ght_pkg::RES_PARENT: res_q <= ep_rd;
				default:             res_q <= '0;
			endcase
		end
	end

	assign done          = done_q;
	assign result_handle = res_q;
	assign found         = found_q;
	assign status        = status_q;

endmodule

// ===== rtl/core/generational_handle_table_top.sv =====
// channel  | handshake          | payload
// command  | start, busy        | func, handle, parent_handle
// result   | done (one cycle)   | result_handle, found, status
//
// Add, query, unused codes and commands on an unknown handle go from S_IDLE
// through S_ONE back to S_IDLE; remove, set parent and get parent on a live
// handle also pass through S_TWO, set by the dependent single-port accesses
// of the slot and entry memories.
// done shows for one cycle after the last step and the result holds until the next one; the receiver cannot stall.
// After reset a clearing pass writes all memories, one slot per cycle, with busy high.
module generational_handle_table_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       func,
	input  ght_pkg::handle_t handle,
	input  ght_pkg::handle_t parent_handle,
	output logic             done,
	output ght_pkg::handle_t result_handle,
	output logic             found,
	output logic [1:0]       status
);

	ght_pkg::cmd_t cmd;
	ght_pkg::sts_t sts;

	ght_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	ght_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.handle        (handle),
		.parent_handle (parent_handle),
		.done          (done),
		.result_handle (result_handle),
		.found         (found),
		.status        (status)
	);

endmodule
